// ----- src/mwcrc_pkg.sv -----
// Shared types, size codes and per-width CRC constants for the
// multi-width CRC byte engine. No dependencies.
package mwcrc_pkg;

    typedef logic [1:0] t_crc_size;

    localparam t_crc_size CRC_SIZE_8  = 2'd0;
    localparam t_crc_size CRC_SIZE_16 = 2'd1;
    localparam t_crc_size CRC_SIZE_32 = 2'd2;

    localparam int unsigned CRC_W  = 32;
    localparam int unsigned BYTE_W = 8;

    // Remainder after reset: the 8-bit initial value, native alignment
    localparam logic [CRC_W-1:0] RESET_REM = 32'h0000_00F1;

    // One transaction on the input channel
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              first_byte;
        logic              last_byte;
    } t_item;

    // Width constants: init and poly are left-justified to bit 31 so one shift
    // network serves all three widths; fx keeps native alignment.
    typedef struct packed {
        logic [CRC_W-1:0] init_al;
        logic [CRC_W-1:0] poly_al;
        logic [CRC_W-1:0] fx;
        logic [4:0]       pad;     // 32 minus the width
    } t_width_cfg;

    function automatic t_width_cfg width_cfg(input t_crc_size sel);
        t_width_cfg c;
        unique case (sel)
            CRC_SIZE_16: begin
                c.init_al = 32'hF1F1_0000;
                c.poly_al = 32'h8408_0000;
                c.fx      = 32'h0000_ABAB;
                c.pad     = 5'd16;
            end
            CRC_SIZE_32: begin
                c.init_al = 32'hF1F1_F1F1;
                c.poly_al = 32'hEDB8_8320;
                c.fx      = 32'hABAB_ABAB;
                c.pad     = 5'd0;
            end
            default: begin
                // 8-bit mode, also the unused size code
                c.init_al = 32'hF100_0000;
                c.poly_al = 32'hE000_0000;
                c.fx      = 32'h0000_00AB;
                c.pad     = 5'd24;
            end
        endcase
        return c;
    endfunction

endpackage

// ----- src/multi_width_crc_byte_engine.sv -----
// Top level of the multi-width CRC byte engine: input register, CRC step,
// result register and the size register. Depends on mwcrc_pkg, mwcrc_step.
// Data path: input register, then the CRC step into the result register.
// Throughput: one byte per cycle while i_out_stall is low, set by the
//   remainder feedback through the unrolled 8-step XOR network.
// Reset (synchronous, i_rst_n low): both stages empty, size 8 bits,
//   remainder 0xF1.
module multi_width_crc_byte_engine import mwcrc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration
    input  logic              i_cfg_wr_en,
    input  logic [1:0]        i_cfg_wr_data,
    // input channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic              i_first_byte,
    input  logic              i_last_byte,
    // output channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [CRC_W-1:0]  o_crc_value,
    output logic              o_message_done
);

    t_crc_size        r_size;
    logic             r_in_vld, n_in_vld;
    t_item            r_in;
    logic [CRC_W-1:0] r_rem;
    logic             r_out_vld, n_out_vld;
    logic [CRC_W-1:0] r_out_crc;
    logic             r_out_done;

    logic             adv;      // input stage moves into result register
    logic             in_load;  // input register takes a new transaction
    logic [CRC_W-1:0] n_rem;
    logic [CRC_W-1:0] step_crc;

    // result register is free, or is being emptied this cycle
    assign adv        = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && !adv;
    assign in_load    = i_in_valid && !o_in_stall;

    assign n_in_vld  = in_load || (r_in_vld && !adv);
    assign n_out_vld = adv || (r_out_vld && i_out_stall);

    // remainder feedback: the item in the input register always sees the
    // remainder left by the previous transaction
    mwcrc_step u_step (
        .i_size (r_size),
        .i_item (r_in),
        .i_rem  (r_rem),
        .o_rem  (n_rem),
        .o_crc  (step_crc)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size    <= CRC_SIZE_8;
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_rem     <= RESET_REM;
        end else begin
            if (i_cfg_wr_en) begin
                r_size <= i_cfg_wr_data;
            end
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
            if (adv) begin
                r_rem <= n_rem;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_in.data_byte  <= i_data_byte;
            r_in.first_byte <= i_first_byte;
            r_in.last_byte  <= i_last_byte;
        end
        if (adv) begin
            r_out_crc  <= step_crc;
            r_out_done <= r_in.last_byte;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_crc_value    = r_out_crc;
    assign o_message_done = r_out_done;

endmodule

// ----- src/mwcrc_step.sv -----
// Combinational byte step of the CRC: reseed on a first byte, absorb one byte, eight
// MSB-first shift steps, final XOR. Depends on mwcrc_pkg.
module mwcrc_step import mwcrc_pkg::*; (
    input  t_crc_size        i_size,
    input  t_item            i_item,
    input  logic [CRC_W-1:0] i_rem,
    output logic [CRC_W-1:0] o_rem,
    output logic [CRC_W-1:0] o_crc
);

    t_width_cfg       cfg;
    logic [CRC_W-1:0] al;

    always_comb begin
        cfg = width_cfg(i_size);
        // left-justify: the shift also drops bits above the width
        al  = i_item.first_byte ? cfg.init_al : (i_rem << cfg.pad);
        al  = al ^ {i_item.data_byte, {(CRC_W-BYTE_W){1'b0}}};
        for (int i = 0; i < BYTE_W; i++) begin
            al = al[CRC_W-1] ? ((al << 1) ^ cfg.poly_al) : (al << 1);
        end
        o_rem = al >> cfg.pad;
        o_crc = o_rem ^ cfg.fx;
    end

endmodule

// ----- src/mwcrc_chk.sv -----
// Port-level checker for the multi-width CRC byte engine, bound to the
// top level. Depends on mwcrc_pkg.
module mwcrc_chk import mwcrc_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [CRC_W-1:0]  o_crc_value,
    input logic              o_message_done
);

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // input only backs up when the result register is full and stalled
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without output back-pressure");

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_crc_value) && $stable(o_message_done)))
        else $error("stalled result changed");

endmodule

bind multi_width_crc_byte_engine mwcrc_chk u_chk (.*);
